// ----- rtl/cafu_pkg.sv -----
package cafu_pkg;

  // Fraction bits of one degree carried by angles and rates.
  localparam int ANGLE_FRAC_BITS = 8;

  // Input and output field widths.
  localparam int ACCEL_W = 16;
  localparam int RATE_W  = 18;
  localparam int DT_W    = 16;
  localparam int ANGLE_W = 17;
  localparam int YAW_W   = 32;
  localparam int WEIGHT_W = 17;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam logic [WEIGHT_W-1:0] GYRO_WEIGHT_RST  = 17'd64225;
  localparam logic [WEIGHT_W-1:0] ACCEL_WEIGHT_RST = 17'd1311;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GYRO_OFS_X  = 3'd0,
    CFG_GYRO_OFS_Y  = 3'd1,
    CFG_GYRO_OFS_Z  = 3'd2,
    CFG_GYRO_WEIGHT = 3'd3,
    CFG_ACCEL_WEIGHT = 3'd4
  } cfg_idx_t;

  // CORDIC vectoring unit.
  localparam int CORDIC_STEPS    = 20;
  localparam int CORDIC_IT_W     = $clog2(CORDIC_STEPS);
  localparam int CORDIC_W        = 34;
  localparam int CORDIC_PRESHIFT = 14;
  localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Rounded division by 1000 = 125 * 2^3, the quotient by 125 taken with a
  // reciprocal multiply and one correction step.
  localparam int  MS_HALF  = 500;
  localparam int  MS_SHIFT = 3;
  localparam int  MS_DIV   = 125;
  localparam int  MS_K     = 31;
  localparam longint MS_RECIP = (64'sd1 <<< MS_K) / MS_DIV;

  // Radians in Q30 to degrees: multiply by 630, then rounded division by
  // 11 * 2^(30 - ANGLE_FRAC_BITS).
  localparam int  TILT_MUL  = 630;
  localparam int  DEG_SHIFT = 30 - ANGLE_FRAC_BITS;
  localparam int  DEG_DIV   = 11;
  localparam longint DEG_HALF = 64'sd11 <<< (DEG_SHIFT - 1);
  localparam int  DEG_K     = 24;
  localparam longint DEG_RECIP = (64'sd1 <<< DEG_K) / DEG_DIV;

  // Saturation limit of roll and pitch, 180 degrees.
  localparam int ANGLE_LIM = 180 <<< ANGLE_FRAC_BITS;

  // Working widths of the datapath.
  localparam int GYRO_W  = RATE_W + 1;
  localparam int DELTA_W = 26;
  localparam int QUO_W   = 26;
  localparam int SCALE_W = 32;
  localparam int SUM_W   = 46;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TILT_START,
    ST_TILT_WAIT,
    ST_PROD,
    ST_SCALE,
    ST_FIX,
    ST_BL_G,
    ST_BL_A,
    ST_BL_S,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    JOB_RATE_X,
    JOB_RATE_Y,
    JOB_RATE_Z,
    JOB_TILT_ROLL,
    JOB_TILT_PITCH
  } job_t;

  typedef struct packed {
    logic                       start;
    logic signed [ACCEL_W-1:0]  num;
    logic signed [RATE_W-1:0]   den;
  } cor_req_t;

  typedef struct packed {
    logic                        done;
    logic signed [CORDIC_W-1:0]  theta;
  } cor_rsp_t;

  // Arctangent of 2^-i in Q30 radians.
  function automatic logic [31:0] atan_q30(input logic [CORDIC_IT_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd843314856;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043836;
      5'd3:  v = 32'd133525158;
      5'd4:  v = 32'd67021686;
      5'd5:  v = 32'd33543515;
      5'd6:  v = 32'd16775850;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194282;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048575;
      5'd11: v = 32'd524287;
      5'd12: v = 32'd262143;
      5'd13: v = 32'd131071;
      5'd14: v = 32'd65535;
      5'd15: v = 32'd32767;
      5'd16: v = 32'd16383;
      5'd17: v = 32'd8191;
      5'd18: v = 32'd4095;
      5'd19: v = 32'd2047;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/cafu_chan_if.sv -----
interface cafu_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [cafu_pkg::ACCEL_W-1:0]        accel_x;
  logic signed [cafu_pkg::ACCEL_W-1:0]        accel_y;
  logic signed [cafu_pkg::ACCEL_W-1:0]        accel_z;
  logic signed [cafu_pkg::RATE_W-1:0]         rate_x;
  logic signed [cafu_pkg::RATE_W-1:0]         rate_y;
  logic signed [cafu_pkg::RATE_W-1:0]         rate_z;
  logic [cafu_pkg::DT_W-1:0]                  elapsed_ms;

  modport source (
    output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, elapsed_ms,
    input  ready
  );
  modport sink (
    input  valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, elapsed_ms,
    output ready
  );
endinterface

interface cafu_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [cafu_pkg::ANGLE_W-1:0]        roll_angle;
  logic signed [cafu_pkg::ANGLE_W-1:0]        pitch_angle;
  logic signed [cafu_pkg::YAW_W-1:0]          yaw_step;

  modport source (
    output valid, roll_angle, pitch_angle, yaw_step,
    input  ready
  );
  modport sink (
    input  valid, roll_angle, pitch_angle, yaw_step,
    output ready
  );
endinterface

// ----- rtl/complementary_attitude_filter_unit.sv -----
// A request is accepted only when idle. It takes two 20-step passes of the shared CORDIC,
// then the rate, tilt and blend steps on the single shared multiplier, and its result is
// loaded into the output register; the load waits while a held result is not yet taken, and
// only after it does the unit go idle to take the next request.
// Reset (synchronous, rst_n low) clears roll and pitch to zero, the gyro offsets to zero and
// the weights to 64225 and 1311 (0.98 and 0.02 in Q1.16); no result is pending after reset.
module complementary_attitude_filter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cafu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cafu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  cafu_in_if.sink                             in_ch,
  cafu_out_if.source                          out_ch
);

  localparam int AW = cafu_pkg::ANGLE_W;

  // Sequencer state and loop indexes.
  cafu_pkg::state_t state_r, state_nxt;
  cafu_pkg::job_t   job_r;
  logic             tilt_r;
  logic             axis_r;

  // Configuration registers.
  logic signed [cafu_pkg::RATE_W-1:0]   ofs_x_r, ofs_y_r, ofs_z_r;
  logic [cafu_pkg::WEIGHT_W-1:0]        gw_r, aw_r;

  // Latched request operands, gyro offsets already removed.
  logic signed [cafu_pkg::ACCEL_W-1:0]  ax_r, ay_r, az_r;
  logic signed [cafu_pkg::GYRO_W-1:0]   gx_r, gy_r, gz_r;
  logic [cafu_pkg::DT_W-1:0]            dt_r;

  // Intermediate results.
  logic signed [cafu_pkg::CORDIC_W-1:0] th_roll_r, th_pitch_r;
  logic [cafu_pkg::SCALE_W-1:0]         v_r;
  logic                                 neg_r;
  logic signed [cafu_pkg::DELTA_W-1:0]  dx_r, dy_r, yaw_r;
  logic signed [AW-1:0]                 acc_roll_r, acc_pitch_r;
  logic signed [cafu_pkg::SUM_W-1:0]    psum_r;

  // Filter state and the output register.
  logic signed [AW-1:0]                 roll_r, pitch_r;
  logic signed [AW-1:0]                 out_roll_r, out_pitch_r;
  logic signed [cafu_pkg::YAW_W-1:0]    out_yaw_r;
  logic                                 out_valid_r;

  logic in_acc, out_load;

  // Shared units.
  cafu_pkg::cor_req_t cor_req;
  cafu_pkg::cor_rsp_t cor_rsp;
  logic signed [cafu_pkg::MUL_A_W-1:0] mul_a;
  logic signed [cafu_pkg::MUL_B_W-1:0] mul_b;
  logic signed [cafu_pkg::MUL_P_W-1:0] mul_p;
  logic [cafu_pkg::MUL_P_W-1:0]        mul_pu;

  cafu_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req),
    .rsp   (cor_rsp)
  );

  cafu_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  assign mul_pu = mul_p;
  assign in_acc = in_ch.valid && in_ch.ready;

  // Tilt operands. Roll uses atan2(y, z + |x|) and pitch uses atan2(x, z + |y|),
  // the pitch sign being applied after the degree conversion.
  logic signed [cafu_pkg::ACCEL_W-1:0] tilt_num, tilt_oth;
  logic signed [cafu_pkg::ACCEL_W:0]   oth_ext, oth_abs;

  always_comb begin
    tilt_num = tilt_r ? ax_r : ay_r;
    tilt_oth = tilt_r ? ay_r : ax_r;
    oth_ext  = (cafu_pkg::ACCEL_W + 1)'(tilt_oth);
    oth_abs  = oth_ext[cafu_pkg::ACCEL_W] ? -oth_ext : oth_ext;
  end

  // Rate jobs divide by one thousand; tilt jobs convert Q30 radians to degrees.
  logic is_rate;
  assign is_rate = (job_r == cafu_pkg::JOB_RATE_X) || (job_r == cafu_pkg::JOB_RATE_Y) ||
                   (job_r == cafu_pkg::JOB_RATE_Z);

  // Scale step: magnitude of the product, add half the divisor, drop the power-of-two
  // part of the divisor. What remains is divided by a small odd constant.
  logic signed [44:0] n45, mag;
  logic               n_neg;
  logic [44:0]        mag_rnd;
  logic [cafu_pkg::SCALE_W-1:0] scale_v;

  always_comb begin
    n45   = mul_p[44:0];
    n_neg = n45[44];
    mag   = n_neg ? -n45 : n45;
    if (is_rate) begin
      mag_rnd = 45'(mag) + 45'(cafu_pkg::MS_HALF);
      scale_v = cafu_pkg::SCALE_W'(mag_rnd >> cafu_pkg::MS_SHIFT);
    end else begin
      mag_rnd = 45'(mag) + 45'(cafu_pkg::DEG_HALF);
      scale_v = cafu_pkg::SCALE_W'(mag_rnd >> cafu_pkg::DEG_SHIFT);
    end
  end

  // Fix step: the reciprocal product undershoots the quotient by at most one, so a
  // single compare of the remainder against the divisor corrects it.
  logic [cafu_pkg::QUO_W-1:0]   q0, quo;
  logic [cafu_pkg::SCALE_W-1:0] cdiv, qc, rem;
  logic signed [cafu_pkg::QUO_W:0] quo_s;

  always_comb begin
    if (is_rate) begin
      q0   = cafu_pkg::QUO_W'(mul_pu >> cafu_pkg::MS_K);
      cdiv = cafu_pkg::SCALE_W'(cafu_pkg::MS_DIV);
    end else begin
      q0   = cafu_pkg::QUO_W'(mul_pu >> cafu_pkg::DEG_K);
      cdiv = cafu_pkg::SCALE_W'(cafu_pkg::DEG_DIV);
    end
    // Each divisor is a constant, so both products reduce to shifts and adds.
    qc    = is_rate ? cafu_pkg::SCALE_W'(q0) * cafu_pkg::SCALE_W'(cafu_pkg::MS_DIV) :
                      cafu_pkg::SCALE_W'(q0) * cafu_pkg::SCALE_W'(cafu_pkg::DEG_DIV);
    rem   = v_r - qc;
    quo   = (rem >= cdiv) ? q0 + 1'b1 : q0;
    quo_s = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  // Blend: gyro_weight * (estimate + rate * dt) + accel_weight * tilt, then round half up
  // by 16 bits and saturate to 180 degrees.
  logic signed [AW-1:0]                est_sel, acc_sel;
  logic signed [cafu_pkg::DELTA_W-1:0] delta_sel;
  logic signed [cafu_pkg::DELTA_W:0]   blend_base;
  logic signed [cafu_pkg::SUM_W-1:0]   blend_sum, blend_sh;
  logic signed [AW-1:0]                blend_res;

  always_comb begin
    est_sel    = axis_r ? pitch_r : roll_r;
    delta_sel  = axis_r ? dy_r : dx_r;
    acc_sel    = axis_r ? acc_pitch_r : acc_roll_r;
    blend_base = (cafu_pkg::DELTA_W + 1)'(est_sel) + (cafu_pkg::DELTA_W + 1)'(delta_sel);
    blend_sum  = psum_r + cafu_pkg::SUM_W'(mul_p);
    blend_sh   = (blend_sum + cafu_pkg::SUM_W'(32768)) >>> 16;
    if (blend_sh > cafu_pkg::SUM_W'(cafu_pkg::ANGLE_LIM)) begin
      blend_res = AW'(cafu_pkg::ANGLE_LIM);
    end else if (blend_sh < -cafu_pkg::SUM_W'(cafu_pkg::ANGLE_LIM)) begin
      blend_res = -AW'(cafu_pkg::ANGLE_LIM);
    end else begin
      blend_res = AW'(blend_sh);
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cafu_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = cafu_pkg::ST_TILT_START;
        end
      end
      cafu_pkg::ST_TILT_START: state_nxt = cafu_pkg::ST_TILT_WAIT;
      cafu_pkg::ST_TILT_WAIT: begin
        if (cor_rsp.done) begin
          state_nxt = tilt_r ? cafu_pkg::ST_PROD : cafu_pkg::ST_TILT_START;
        end
      end
      cafu_pkg::ST_PROD:  state_nxt = cafu_pkg::ST_SCALE;
      cafu_pkg::ST_SCALE: state_nxt = cafu_pkg::ST_FIX;
      cafu_pkg::ST_FIX: begin
        state_nxt = (job_r == cafu_pkg::JOB_TILT_PITCH) ? cafu_pkg::ST_BL_G :
                                                          cafu_pkg::ST_PROD;
      end
      cafu_pkg::ST_BL_G: state_nxt = cafu_pkg::ST_BL_A;
      cafu_pkg::ST_BL_A: state_nxt = cafu_pkg::ST_BL_S;
      cafu_pkg::ST_BL_S: state_nxt = axis_r ? cafu_pkg::ST_DONE : cafu_pkg::ST_BL_G;
      cafu_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = cafu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cafu_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, CORDIC start and the multiplier operand selection.
  // Each multiplier step issues operands in one state; the product is read in the next.
  always_comb begin
    in_ch.ready   = 1'b0;
    out_load      = 1'b0;
    cor_req.start = 1'b0;
    cor_req.num   = tilt_num;
    cor_req.den   = cafu_pkg::RATE_W'(az_r) + cafu_pkg::RATE_W'(oth_abs);
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_r)
      cafu_pkg::ST_IDLE:       in_ch.ready = 1'b1;
      cafu_pkg::ST_TILT_START: cor_req.start = 1'b1;
      cafu_pkg::ST_TILT_WAIT:  ;
      cafu_pkg::ST_PROD: begin
        case (job_r)
          cafu_pkg::JOB_RATE_X: begin
            mul_a = cafu_pkg::MUL_A_W'(gx_r);
            mul_b = $signed(cafu_pkg::MUL_B_W'(dt_r));
          end
          cafu_pkg::JOB_RATE_Y: begin
            mul_a = cafu_pkg::MUL_A_W'(gy_r);
            mul_b = $signed(cafu_pkg::MUL_B_W'(dt_r));
          end
          cafu_pkg::JOB_RATE_Z: begin
            mul_a = cafu_pkg::MUL_A_W'(gz_r);
            mul_b = $signed(cafu_pkg::MUL_B_W'(dt_r));
          end
          cafu_pkg::JOB_TILT_ROLL: begin
            mul_a = th_roll_r;
            mul_b = cafu_pkg::MUL_B_W'(cafu_pkg::TILT_MUL);
          end
          default: begin
            mul_a = th_pitch_r;
            mul_b = cafu_pkg::MUL_B_W'(cafu_pkg::TILT_MUL);
          end
        endcase
      end
      cafu_pkg::ST_SCALE: begin
        mul_a = $signed(cafu_pkg::MUL_A_W'(scale_v));
        mul_b = is_rate ? cafu_pkg::MUL_B_W'(cafu_pkg::MS_RECIP) :
                          cafu_pkg::MUL_B_W'(cafu_pkg::DEG_RECIP);
      end
      cafu_pkg::ST_FIX: ;
      cafu_pkg::ST_BL_G: begin
        mul_a = cafu_pkg::MUL_A_W'(blend_base);
        mul_b = $signed(cafu_pkg::MUL_B_W'(gw_r));
      end
      cafu_pkg::ST_BL_A: begin
        mul_a = cafu_pkg::MUL_A_W'(acc_sel);
        mul_b = $signed(cafu_pkg::MUL_B_W'(aw_r));
      end
      cafu_pkg::ST_BL_S: ;
      cafu_pkg::ST_DONE: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // Control state, configuration and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cafu_pkg::ST_IDLE;
      job_r       <= cafu_pkg::JOB_RATE_X;
      tilt_r      <= 1'b0;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ofs_x_r     <= '0;
      ofs_y_r     <= '0;
      ofs_z_r     <= '0;
      gw_r        <= cafu_pkg::GYRO_WEIGHT_RST;
      aw_r        <= cafu_pkg::ACCEL_WEIGHT_RST;
      roll_r      <= '0;
      pitch_r     <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cafu_pkg::cfg_idx_t'(cfg_index))
          cafu_pkg::CFG_GYRO_OFS_X:   ofs_x_r <= $signed(cfg_wdata);
          cafu_pkg::CFG_GYRO_OFS_Y:   ofs_y_r <= $signed(cfg_wdata);
          cafu_pkg::CFG_GYRO_OFS_Z:   ofs_z_r <= $signed(cfg_wdata);
          cafu_pkg::CFG_GYRO_WEIGHT:  gw_r <= cfg_wdata[cafu_pkg::WEIGHT_W-1:0];
          cafu_pkg::CFG_ACCEL_WEIGHT: aw_r <= cfg_wdata[cafu_pkg::WEIGHT_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        tilt_r <= 1'b0;
        job_r  <= cafu_pkg::JOB_RATE_X;
        axis_r <= 1'b0;
      end
      if (state_r == cafu_pkg::ST_TILT_WAIT && cor_rsp.done) begin
        tilt_r <= 1'b1;
      end
      if (state_r == cafu_pkg::ST_FIX && job_r != cafu_pkg::JOB_TILT_PITCH) begin
        job_r <= cafu_pkg::job_t'(job_r + 3'd1);
      end
      if (state_r == cafu_pkg::ST_BL_S) begin
        axis_r <= 1'b1;
        if (axis_r) begin
          pitch_r <= blend_res;
        end else begin
          roll_r <= blend_res;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_r <= in_ch.accel_x;
      ay_r <= in_ch.accel_y;
      az_r <= in_ch.accel_z;
      gx_r <= cafu_pkg::GYRO_W'(in_ch.rate_x) - cafu_pkg::GYRO_W'(ofs_x_r);
      gy_r <= cafu_pkg::GYRO_W'(in_ch.rate_y) - cafu_pkg::GYRO_W'(ofs_y_r);
      gz_r <= cafu_pkg::GYRO_W'(in_ch.rate_z) - cafu_pkg::GYRO_W'(ofs_z_r);
      dt_r <= in_ch.elapsed_ms;
    end

    if (state_r == cafu_pkg::ST_TILT_WAIT && cor_rsp.done) begin
      if (tilt_r) begin
        th_pitch_r <= cor_rsp.theta;
      end else begin
        th_roll_r <= cor_rsp.theta;
      end
    end

    if (state_r == cafu_pkg::ST_SCALE) begin
      v_r   <= scale_v;
      neg_r <= n_neg;
    end

    if (state_r == cafu_pkg::ST_FIX) begin
      case (job_r)
        cafu_pkg::JOB_RATE_X:    dx_r <= cafu_pkg::DELTA_W'(quo_s);
        cafu_pkg::JOB_RATE_Y:    dy_r <= cafu_pkg::DELTA_W'(quo_s);
        cafu_pkg::JOB_RATE_Z:    yaw_r <= cafu_pkg::DELTA_W'(quo_s);
        cafu_pkg::JOB_TILT_ROLL: acc_roll_r <= AW'(quo_s);
        default:                 acc_pitch_r <= -AW'(quo_s);
      endcase
    end

    if (state_r == cafu_pkg::ST_BL_A) begin
      psum_r <= cafu_pkg::SUM_W'(mul_p);
    end

    if (out_load) begin
      out_roll_r  <= roll_r;
      out_pitch_r <= pitch_r;
      out_yaw_r   <= cafu_pkg::YAW_W'(yaw_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.roll_angle  = out_roll_r;
  assign out_ch.pitch_angle = out_pitch_r;
  assign out_ch.yaw_step    = out_yaw_r;

`ifndef SYNTHESIS
  // The CORDIC only finishes while the sequencer is waiting for it.
  a_cordic_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cor_rsp.done |-> state_r == cafu_pkg::ST_TILT_WAIT)
    else $error("CORDIC finished outside its wait state");

  // A taken request keeps the input closed while it is processed.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input reopened right after a request was taken");

  // The filter state never leaves the saturation range.
  a_estimate_range: assert property (@(posedge clk) disable iff (!rst_n)
    (roll_r <= AW'(cafu_pkg::ANGLE_LIM)) && (roll_r >= -AW'(cafu_pkg::ANGLE_LIM)) &&
    (pitch_r <= AW'(cafu_pkg::ANGLE_LIM)) && (pitch_r >= -AW'(cafu_pkg::ANGLE_LIM)))
    else $error("roll or pitch estimate outside 180 degrees");
`endif

endmodule

// ----- rtl/cafu_mul.sv -----
// Shared signed multiplier with a registered product.
module cafu_mul (
  input  logic                                 clk,
  input  logic signed [cafu_pkg::MUL_A_W-1:0]  mul_a,
  input  logic signed [cafu_pkg::MUL_B_W-1:0]  mul_b,
  output logic signed [cafu_pkg::MUL_P_W-1:0]  mul_p
);

  logic signed [cafu_pkg::MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= cafu_pkg::MUL_P_W'(mul_a) * cafu_pkg::MUL_P_W'(mul_b);
  end

  assign mul_p = prod_r;

endmodule

// ----- rtl/cafu_cordic.sv -----
// Iterative vectoring CORDIC: one micro-rotation per cycle.
module cafu_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cafu_pkg::cor_req_t   req,
  output cafu_pkg::cor_rsp_t   rsp
);

  localparam int W = cafu_pkg::CORDIC_W;

  logic signed [W-1:0] x_r, y_r, th_r;
  logic signed [W-1:0] x_nxt, y_nxt, th_nxt;
  logic [cafu_pkg::CORDIC_IT_W-1:0] it_r;
  logic run_r, done_r, zero_r;
  logic last;

  logic signed [W-1:0] x0, y0;
  logic signed [W-1:0] dx, dy, step_ang;

  assign x0 = W'(req.den) <<< cafu_pkg::CORDIC_PRESHIFT;
  assign y0 = W'(req.num) <<< cafu_pkg::CORDIC_PRESHIFT;

  assign last = (it_r == cafu_pkg::CORDIC_IT_W'(cafu_pkg::CORDIC_STEPS - 1));

  always_comb begin
    dx = y_r >>> it_r;
    dy = x_r >>> it_r;
    step_ang = $signed({2'b00, cafu_pkg::atan_q30(it_r)});
    if (!y_r[W-1]) begin
      x_nxt  = x_r + dx;
      y_nxt  = y_r - dy;
      th_nxt = th_r + step_ang;
    end else begin
      x_nxt  = x_r - dx;
      y_nxt  = y_r + dy;
      th_nxt = th_r - step_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= run_r && last;
      if (req.start) begin
        run_r <= 1'b1;
        it_r  <= '0;
      end else if (run_r) begin
        it_r <= it_r + 1'b1;
        if (last) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      zero_r <= (req.num == '0) && (req.den == '0);
      // A vector in the left half plane is first turned by a quarter turn.
      if (x0 < 0) begin
        if (!y0[W-1]) begin
          x_r  <= y0;
          y_r  <= -x0;
          th_r <= cafu_pkg::HALF_PI_Q30;
        end else begin
          x_r  <= -y0;
          y_r  <= x0;
          th_r <= -cafu_pkg::HALF_PI_Q30;
        end
      end else begin
        x_r  <= x0;
        y_r  <= y0;
        th_r <= '0;
      end
    end else if (run_r) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      th_r <= th_nxt;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.theta = zero_r ? '0 : th_r;

endmodule
